// ===== hdl/psd_pkg.sv =====
// Shared types and constants for the point-to-segment distance core.
`timescale 1ns / 1ps
package psd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int LAM_BITS = 32;
	localparam int AXES = 3;
	localparam int DIV_STEPS = 32;
	localparam int SQRT_STEPS = 33;
	localparam int DIFF_W = 33;
	localparam int NORM_W = 66;
	localparam int LAM_W = 33;
	localparam int RAD_W = 66;
	localparam int SREM_W = 35;
	localparam int ROOT_W = 33;
	localparam int DIST_W = 34;
	localparam int POS_W = 17;

	localparam logic [1:0] REGION_INTERIOR = 2'd0;
	localparam logic [1:0] REGION_START = 2'd1;
	localparam logic [1:0] REGION_END = 2'd2;

	localparam logic [1:0] DIM_PLANAR = 2'd2;
	localparam logic [1:0] DIM_RESET = 2'd3;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
		logic signed [31:0] query_x;
		logic signed [31:0] query_y;
		logic signed [31:0] query_z;
	} item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [POS_W-1:0] position;
		logic [1:0] region;
		logic degenerate;
	} result_t;

	// Data that rides along the divider chain untouched.
	typedef struct packed {
		logic [AXES-1:0][DIFF_W-1:0] w;
		logic [AXES-1:0][DIFF_W-1:0] qe;
		logic [AXES-1:0][DIFF_W-1:0] magd;
		logic [AXES-1:0] dneg;
		logic [1:0] region;
		logic degen;
	} div_side_t;

	// Data that rides along the square root chain untouched.
	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [1:0] region;
		logic degen;
	} sqrt_side_t;

endpackage

// ===== hdl/point_segment_distance_core.sv =====
// Top level of the point-to-segment distance core.
`timescale 1ns / 1ps
// Streams point-to-segment distance queries at one item per clock. An item is
// taken whenever start is high; busy is tied low, because nothing in the block
// ever needs to hold an item off. Every item produces exactly one result, which
// appears on result for a single cycle with done high. The receiver cannot
// stall this transfer, so it must take every result in the cycle it is shown.
// The pipeline holds four front stages (differences, products, sums,
// classification), a row of 32 divider cells forming the segment parameter one
// bit per cell, four stages forming the offset and the squared distance, and a
// row of 33 square root cells forming the distance one bit per cell. The
// dimension register is written through cfg_valid/cfg_ready/cfg_data (cfg_ready
// is always high) and should only change while no item is in flight; a value
// of 2 ignores z.
module point_segment_distance_core (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  psd_pkg::item_t item,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_data,
	output logic done,
	output psd_pkg::result_t result
);
	import psd_pkg::*;

	logic [1:0] dim_q;

	// Front stages.
	logic vld_s1, vld_s2, vld_s3;
	logic [AXES-1:0][DIFF_W-1:0] w_s1, d_s1, qe_s1;
	logic [AXES-1:0][DIFF_W-1:0] w_s2, d_s2, qe_s2;
	logic [AXES-1:0][DIFF_W-1:0] w_s3, d_s3, qe_s3;
	logic signed [65:0] wd_s2 [AXES];
	logic signed [65:0] dd_s2 [AXES];
	logic signed [67:0] dot_s3;
	logic [NORM_W-1:0] norm_s3;

	logic [31:0] s_c [AXES];
	logic [31:0] e_c [AXES];
	logic [31:0] q_c [AXES];
	logic [AXES-1:0] axis_en;

	// Divider row.
	logic div_vld [DIV_STEPS+1];
	logic [NORM_W-1:0] div_rem [DIV_STEPS+1];
	logic [NORM_W-1:0] div_norm [DIV_STEPS+1];
	logic [LAM_W-1:0] div_quot [DIV_STEPS+1];
	div_side_t div_side [DIV_STEPS+1];

	// Back stages.
	logic vld_m1, vld_m2, vld_m3, vld_m4;
	logic [65:0] prod_m1 [AXES];
	div_side_t side_m1;
	logic [POS_W-1:0] pos_m1;
	logic [34:0] diff_m2 [AXES];
	sqrt_side_t side_m2, side_m3, side_m4;
	logic [67:0] sq_m3 [AXES];
	logic [RAD_W-1:0] sum_m4;

	// Square root row.
	logic sq_vld [SQRT_STEPS+1];
	logic [RAD_W-1:0] sq_rad [SQRT_STEPS+1];
	logic [SREM_W-1:0] sq_rem [SQRT_STEPS+1];
	logic [ROOT_W-1:0] sq_root [SQRT_STEPS+1];
	sqrt_side_t sq_side [SQRT_STEPS+1];

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dim_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_m1 <= 1'b0;
			vld_m2 <= 1'b0;
			vld_m3 <= 1'b0;
			vld_m4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_m1 <= div_vld[DIV_STEPS];
			vld_m2 <= vld_m1;
			vld_m3 <= vld_m2;
			vld_m4 <= vld_m3;
		end
	end

	// Stage 1: per-axis differences. Unused axes are forced to zero, which
	// removes them from the dot product, the norm and every distance.
	always_comb begin
		s_c[0] = item.start_x;
		s_c[1] = item.start_y;
		s_c[2] = item.start_z;
		e_c[0] = item.end_x;
		e_c[1] = item.end_y;
		e_c[2] = item.end_z;
		q_c[0] = item.query_x;
		q_c[1] = item.query_y;
		q_c[2] = item.query_z;
		axis_en = {dim_q != DIM_PLANAR, 2'b11};
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < AXES; i++) begin
			if (axis_en[i]) begin
				w_s1[i] <= {q_c[i][31], q_c[i]} - {s_c[i][31], s_c[i]};
				d_s1[i] <= {e_c[i][31], e_c[i]} - {s_c[i][31], s_c[i]};
				qe_s1[i] <= {q_c[i][31], q_c[i]} - {e_c[i][31], e_c[i]};
			end else begin
				w_s1[i] <= '0;
				d_s1[i] <= '0;
				qe_s1[i] <= '0;
			end
		end
	end

	// Stage 2: one product per axis for the dot product and one for the norm.
	always_ff @(posedge clk) begin
		for (int i = 0; i < AXES; i++) begin
			wd_s2[i] <= $signed(w_s1[i]) * $signed(d_s1[i]);
			dd_s2[i] <= $signed(d_s1[i]) * $signed(d_s1[i]);
		end
		w_s2 <= w_s1;
		d_s2 <= d_s1;
		qe_s2 <= qe_s1;
	end

	// Stage 3: exact sums. The norm is never negative and stays below 2^66.
	always_ff @(posedge clk) begin
		dot_s3 <= 68'(wd_s2[0]) + 68'(wd_s2[1]) + 68'(wd_s2[2]);
		norm_s3 <= NORM_W'(dd_s2[0]) + NORM_W'(dd_s2[1]) + NORM_W'(dd_s2[2]);
		w_s3 <= w_s2;
		d_s3 <= d_s2;
		qe_s3 <= qe_s2;
	end

	// Stage 4: classification, then the divider row is loaded. A zero norm and
	// a negative dot product both clamp to the start point; a dot product past
	// the norm clamps to the end. Inside the segment the quotient has a top bit
	// that is set only when the dot product equals the norm exactly.
	logic degen_c, neg_c, beyond_c, full_c;
	logic [1:0] region_c;
	div_side_t side_c;

	always_comb begin
		degen_c = norm_s3 == '0;
		neg_c = dot_s3[67];
		beyond_c = dot_s3 > {2'b00, norm_s3};
		full_c = dot_s3 == {2'b00, norm_s3};
		if (degen_c || neg_c) begin
			region_c = REGION_START;
		end else if (beyond_c) begin
			region_c = REGION_END;
		end else begin
			region_c = REGION_INTERIOR;
		end
		side_c.w = w_s3;
		side_c.qe = qe_s3;
		for (int i = 0; i < AXES; i++) begin
			side_c.dneg[i] = d_s3[i][DIFF_W-1];
			side_c.magd[i] = d_s3[i][DIFF_W-1] ? DIFF_W'(-d_s3[i]) : d_s3[i];
		end
		side_c.region = region_c;
		side_c.degen = degen_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld[0] <= 1'b0;
		end else begin
			div_vld[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		div_norm[0] <= norm_s3;
		div_side[0] <= side_c;
		if (region_c == REGION_INTERIOR && !full_c) begin
			div_rem[0] <= dot_s3[NORM_W-1:0];
		end else begin
			div_rem[0] <= '0;
		end
		div_quot[0] <= {{(LAM_W-1){1'b0}}, region_c == REGION_INTERIOR && full_c};
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		psd_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.vld_in(div_vld[k]),
			.rem_in(div_rem[k]),
			.norm_in(div_norm[k]),
			.quot_in(div_quot[k]),
			.side_in(div_side[k]),
			.vld_q(div_vld[k+1]),
			.rem_q(div_rem[k+1]),
			.norm_q(div_norm[k+1]),
			.quot_q(div_quot[k+1]),
			.side_q(div_side[k+1])
		);
	end

	// Back stage 1: scaled offsets along the segment, and the clamped position.
	always_ff @(posedge clk) begin
		for (int i = 0; i < AXES; i++) begin
			prod_m1[i] <= div_side[DIV_STEPS].magd[i] * div_quot[DIV_STEPS];
		end
		side_m1 <= div_side[DIV_STEPS];
		case (div_side[DIV_STEPS].region)
			REGION_INTERIOR: pos_m1 <= POS_W'(div_quot[DIV_STEPS] >> (LAM_BITS - FRAC_BITS));
			REGION_END: pos_m1 <= POS_W'(1 << FRAC_BITS);
			default: pos_m1 <= '0;
		endcase
	end

	// Back stage 2: offset rounded half away from zero, then the vector from
	// the nearest point to the query point.
	logic [66:0] rnd_c [AXES];
	logic [33:0] off_c [AXES];

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			rnd_c[i] = {1'b0, prod_m1[i]} + 67'(64'h8000_0000);
			off_c[i] = rnd_c[i][65:32];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < AXES; i++) begin
			case (side_m1.region)
				REGION_INTERIOR: begin
					if (side_m1.dneg[i]) begin
						diff_m2[i] <= {{2{side_m1.w[i][DIFF_W-1]}}, side_m1.w[i]} + {1'b0, off_c[i]};
					end else begin
						diff_m2[i] <= {{2{side_m1.w[i][DIFF_W-1]}}, side_m1.w[i]} - {1'b0, off_c[i]};
					end
				end
				REGION_END: diff_m2[i] <= {{2{side_m1.qe[i][DIFF_W-1]}}, side_m1.qe[i]};
				default: diff_m2[i] <= {{2{side_m1.w[i][DIFF_W-1]}}, side_m1.w[i]};
			endcase
		end
		side_m2.position <= pos_m1;
		side_m2.region <= side_m1.region;
		side_m2.degen <= side_m1.degen;
	end

	// Back stage 3: squares of the magnitudes.
	logic [33:0] mag_c [AXES];

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			mag_c[i] = diff_m2[i][34] ? 34'(-diff_m2[i]) : diff_m2[i][33:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < AXES; i++) begin
			sq_m3[i] <= mag_c[i] * mag_c[i];
		end
		side_m3 <= side_m2;
	end

	// Back stage 4: squared distance, below 2^66 for any input.
	always_ff @(posedge clk) begin
		sum_m4 <= RAD_W'(sq_m3[0] + sq_m3[1] + sq_m3[2]);
		side_m4 <= side_m3;
	end

	assign sq_vld[0] = vld_m4;
	assign sq_rad[0] = sum_m4;
	assign sq_rem[0] = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_m4;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		psd_sqrt_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.vld_in(sq_vld[k]),
			.rad_in(sq_rad[k]),
			.rem_in(sq_rem[k]),
			.root_in(sq_root[k]),
			.side_in(sq_side[k]),
			.vld_q(sq_vld[k+1]),
			.rad_q(sq_rad[k+1]),
			.rem_q(sq_rem[k+1]),
			.root_q(sq_root[k+1]),
			.side_q(sq_side[k+1])
		);
	end

	// The last square root cell is the output register.
	always_comb begin
		done = sq_vld[SQRT_STEPS];
		result.distance = DIST_W'(sq_root[SQRT_STEPS]);
		result.position = sq_side[SQRT_STEPS].position;
		result.region = sq_side[SQRT_STEPS].region;
		result.degenerate = sq_side[SQRT_STEPS].degen;
	end

endmodule

// ===== hdl/psd_div_cell.sv =====
// One restoring division step: yields one quotient bit per cycle.
`timescale 1ns / 1ps
module psd_div_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic vld_in,
	input  logic [psd_pkg::NORM_W-1:0] rem_in,
	input  logic [psd_pkg::NORM_W-1:0] norm_in,
	input  logic [psd_pkg::LAM_W-1:0] quot_in,
	input  psd_pkg::div_side_t side_in,
	output logic vld_q,
	output logic [psd_pkg::NORM_W-1:0] rem_q,
	output logic [psd_pkg::NORM_W-1:0] norm_q,
	output logic [psd_pkg::LAM_W-1:0] quot_q,
	output psd_pkg::div_side_t side_q
);
	import psd_pkg::*;

	logic [NORM_W:0] r2;
	logic [NORM_W:0] diff;
	logic ge;

	always_comb begin
		r2 = {rem_in, 1'b0};
		ge = r2 >= {1'b0, norm_in};
		diff = r2 - {1'b0, norm_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= ge ? diff[NORM_W-1:0] : r2[NORM_W-1:0];
		norm_q <= norm_in;
		quot_q <= {quot_in[LAM_W-2:0], ge};
		side_q <= side_in;
	end

endmodule

// ===== hdl/psd_sqrt_cell.sv =====
// One digit-by-digit square root step: yields one root bit per cycle.
`timescale 1ns / 1ps
module psd_sqrt_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic vld_in,
	input  logic [psd_pkg::RAD_W-1:0] rad_in,
	input  logic [psd_pkg::SREM_W-1:0] rem_in,
	input  logic [psd_pkg::ROOT_W-1:0] root_in,
	input  psd_pkg::sqrt_side_t side_in,
	output logic vld_q,
	output logic [psd_pkg::RAD_W-1:0] rad_q,
	output logic [psd_pkg::SREM_W-1:0] rem_q,
	output logic [psd_pkg::ROOT_W-1:0] root_q,
	output psd_pkg::sqrt_side_t side_q
);
	import psd_pkg::*;

	logic [SREM_W+1:0] rem2;
	logic [SREM_W+1:0] trial;
	logic [SREM_W+1:0] diff;
	logic ge;

	always_comb begin
		rem2 = {rem_in, rad_in[RAD_W-1:RAD_W-2]};
		trial = {{(SREM_W+2-ROOT_W-2){1'b0}}, root_in, 2'b01};
		ge = rem2 >= trial;
		diff = rem2 - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		rad_q <= {rad_in[RAD_W-3:0], 2'b00};
		rem_q <= ge ? diff[SREM_W-1:0] : rem2[SREM_W-1:0];
		root_q <= {root_in[ROOT_W-2:0], ge};
		side_q <= side_in;
	end

endmodule

// ===== sim/point_segment_distance_checker.sv =====
// Result checker for the point-to-segment distance core: predicts each result and compares.
`timescale 1ns / 1ps
module point_segment_distance_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  psd_pkg::item_t item,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [1:0] cfg_data,
	input  logic done,
	input  psd_pkg::result_t result,
	output int unsigned fail_count,
	output int unsigned pending_count,
	output int unsigned result_count
);
	import psd_pkg::*;

	logic [1:0] dim_shadow;
	result_t distance_queue[$];

	function automatic logic [127:0] isqrt_floor(logic [127:0] n);
		logic [127:0] r;
		logic [127:0] c;
		r = '0;
		for (int b = 36; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (c * c <= n) r = c;
		end
		return r;
	endfunction

	function automatic logic [127:0] sq_dist(logic signed [63:0] a[3],
		logic signed [63:0] b[3], int n);
		logic [127:0] acc;
		logic signed [63:0] df;
		logic [127:0] m;
		acc = '0;
		for (int i = 0; i < n; i++) begin
			df = a[i] - b[i];
			m = (df < 0) ? 128'(-df) : 128'(df);
			acc = acc + m * m;
		end
		return acc;
	endfunction

	function automatic result_t predict_distance(item_t it, logic [1:0] dim);
		result_t r;
		logic signed [63:0] s[3], e[3], q[3], d[3], p[3];
		logic [127:0] norm, pos, neg, dot, lam, prod, md, mw;
		logic signed [63:0] w, off;
		int n;
		n = (dim == DIM_PLANAR) ? 2 : 3;
		s[0] = it.start_x; s[1] = it.start_y; s[2] = it.start_z;
		e[0] = it.end_x; e[1] = it.end_y; e[2] = it.end_z;
		q[0] = it.query_x; q[1] = it.query_y; q[2] = it.query_z;
		norm = '0; pos = '0; neg = '0;
		for (int i = 0; i < 3; i++) d[i] = e[i] - s[i];
		for (int i = 0; i < n; i++) begin
			w = q[i] - s[i];
			md = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
			mw = (w < 0) ? 128'(-w) : 128'(w);
			norm = norm + md * md;
			if ((w < 0) != (d[i] < 0)) neg = neg + mw * md;
			else pos = pos + mw * md;
		end
		r.degenerate = 1'b0;
		if (norm == 0) begin
			r.degenerate = 1'b1;
			r.region = REGION_START;
			r.position = '0;
			r.distance = DIST_W'(isqrt_floor(sq_dist(q, s, n)));
		end else if (neg > pos) begin
			r.region = REGION_START;
			r.position = '0;
			r.distance = DIST_W'(isqrt_floor(sq_dist(q, s, n)));
		end else begin
			dot = pos - neg;
			if (dot > norm) begin
				r.region = REGION_END;
				r.position = POS_W'(1 << FRAC_BITS);
				r.distance = DIST_W'(isqrt_floor(sq_dist(q, e, n)));
			end else begin
				// Segment parameter as an unsigned Q1.32 fraction, truncated.
				lam = (dot << 32) / norm;
				r.region = REGION_INTERIOR;
				r.position = POS_W'(lam >> (LAM_BITS - FRAC_BITS));
				for (int i = 0; i < 3; i++) p[i] = s[i];
				for (int i = 0; i < n; i++) begin
					md = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
					prod = md * lam + (128'd1 << 31);
					off = 64'(prod >> 32);
					p[i] = (d[i] < 0) ? s[i] - off : s[i] + off;
				end
				r.distance = DIST_W'(isqrt_floor(sq_dist(q, p, n)));
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t ns: mismatch: %s", $time, what);
		fail_count++;
	endtask

	assign pending_count = distance_queue.size();

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			dim_shadow <= DIM_RESET;
			distance_queue.delete();
			fail_count = 0;
			result_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) dim_shadow <= cfg_data;
			if (start && !busy) distance_queue.push_back(predict_distance(item, dim_shadow));
			if (done) begin
				result_count <= result_count + 1;
				if (distance_queue.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = distance_queue.pop_front();
					if (result.distance !== want.distance)
						report_mismatch($sformatf("distance %0d, expected %0d",
							result.distance, want.distance));
					if (result.position !== want.position)
						report_mismatch($sformatf("position %0d, expected %0d",
							result.position, want.position));
					if (result.region !== want.region)
						report_mismatch($sformatf("region %0d, expected %0d",
							result.region, want.region));
					if (result.degenerate !== want.degenerate)
						report_mismatch($sformatf("degenerate %0d, expected %0d",
							result.degenerate, want.degenerate));
				end
			end
		end
	end
endmodule

// ===== sim/point_segment_distance_core_tb.sv =====
// Testbench top for the point-to-segment distance core: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module point_segment_distance_core_tb;
	import psd_pkg::*;

	// Generous margin to let the pipeline empty after the last result.
	localparam int DRAIN_CYCLES = 100;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t item = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_data = '0;
	logic done;
	result_t result;
	int unsigned fail_count, pending_count, result_count;
	int unsigned item_count = 0;
	int unsigned idle_cycles = 0;
	bit no_gaps = 1'b0;

	always #5 clk = ~clk;

	point_segment_distance_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .result(result)
	);

	point_segment_distance_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .result(result), .fail_count(fail_count),
		.pending_count(pending_count), .result_count(result_count)
	);

	// The watchdog counts cycles in which no item, no result and no configuration write moves.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// A random coordinate, biased toward small values and extremes so
	// that interior projections and clamping are both common.
	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return 32'(signed'($urandom_range(0, 2000)) - 1000);
			3, 4: return 32'($urandom);
			default: return 32'(signed'($urandom_range(0, 32'h000f_ffff)) - 32'h0008_0000);
		endcase
	endfunction

	function automatic item_t rand_item();
		item_t it;
		it.start_x = rand_coord(); it.start_y = rand_coord(); it.start_z = rand_coord();
		it.end_x = rand_coord(); it.end_y = rand_coord(); it.end_z = rand_coord();
		it.query_x = rand_coord(); it.query_y = rand_coord(); it.query_z = rand_coord();
		case ($urandom_range(0, 9))
			// Zero-length segment.
			0: begin
				it.end_x = it.start_x; it.end_y = it.start_y; it.end_z = it.start_z;
			end
			// Zero length in the plane only; matters when z is ignored.
			1: begin
				it.end_x = it.start_x; it.end_y = it.start_y;
			end
			// Query at the end point, which gives lambda of exactly one.
			2: begin
				it.query_x = it.end_x; it.query_y = it.end_y; it.query_z = it.end_z;
			end
			default: ;
		endcase
		return it;
	endfunction

	// Hands one item over and holds it until the core takes it. Start stays
	// high on return, so back-to-back calls with no_gaps set keep the input busy every cycle;
	// the next call or the drain task lowers it.
	task automatic send_item(item_t it);
		while (!no_gaps && $urandom_range(0, 99) < 36) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		item_count++;
		@(negedge clk);
	endtask

	// Waits until every expected result is in, then lets the pipeline empty.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_dimension(logic [1:0] dim);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= dim;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic make_item(output item_t it, input int sx, sy, sz, ex, ey, ez, qx, qy, qz);
		it.start_x = sx; it.start_y = sy; it.start_z = sz;
		it.end_x = ex; it.end_y = ey; it.end_z = ez;
		it.query_x = qx; it.query_y = qy; it.query_z = qz;
	endtask

	initial begin
		item_t it;
		logic [1:0] dim_list[4];
		dim_list = '{DIM_PLANAR, DIM_RESET, 2'd0, 2'd1};
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: interior, both clampings, lambda of one, zero length,
		// and the extreme corners of the coordinate range.
		make_item(it, 0, 0, 0, 65536, 0, 0, 32768, 65536, 0); send_item(it);
		make_item(it, 0, 0, 0, 65536, 0, 0, -65536, 5, 7); send_item(it);
		make_item(it, 0, 0, 0, 65536, 0, 0, 200000, -3, 9); send_item(it);
		make_item(it, 10, 20, 30, 70000, -5, 4, 70000, -5, 4); send_item(it);
		make_item(it, 10, 20, 30, 10, 20, 30, -99, 44, 1); send_item(it);
		make_item(it, 0, 0, 0, 0, 0, 0, 0, 0, 0); send_item(it);
		make_item(it, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000); send_item(it);
		make_item(it, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff); send_item(it);
		make_item(it, -1, -1, -1, 1, 1, 1, 0, 0, 0); send_item(it);
		make_item(it, 3, 3, 0, 3, 3, 1000, 7, 7, 500); send_item(it);
		write_dimension(DIM_PLANAR);
		make_item(it, 3, 3, 0, 3, 3, 1000, 7, 7, 500); send_item(it);
		make_item(it, 0, 0, 5, 65536, 65536, -5, 65536, 0, 32'sh7fff_ffff); send_item(it);
		make_item(it, 32'sh8000_0000, 32'sh8000_0000, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 0,
			32'sh7fff_ffff, 32'sh8000_0000, 0); send_item(it);

		// Random part in phases, each with its own dimension setting. One
		// phase runs with no sender gaps at all.
		for (int ph = 0; ph < 8; ph++) begin
			write_dimension(dim_list[ph % 4]);
			no_gaps = (ph == 3);
			for (int k = 0; k < 230; k++) begin
				send_item(rand_item());
				// Occasionally hold off until the core has answered everything.
				if (k == 100) drain_results();
			end
		end
		no_gaps = 1'b0;
		drain_results();

		$display("Sent %0d items over planar and spatial settings; %0d results checked.",
			item_count, result_count);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
